// File: sv/osf_pkg.sv
// Shared types, constants and helpers for the one-bit speaker sample FIFO.
package osf_pkg;

    localparam int QUEUE_DEPTH   = 1024;
    localparam int MAX_CHANNELS  = 4;
    localparam int SAMPLE_FIELDS = 4;
    localparam int CHAN_LIMIT    = (MAX_CHANNELS < SAMPLE_FIELDS) ? MAX_CHANNELS
                                                                  : SAMPLE_FIELDS;

    localparam int SAMPLE_W     = 16;
    localparam int SUM_W        = 18;
    localparam int CHAN_CNT_W   = 3;
    localparam int COUNT_W      = 32;
    localparam int FILL_LEVEL_W = 11;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);

    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;

    // Register index, taken from paddr bit 2
    localparam logic REG_ENABLE        = 1'b0;
    localparam logic REG_CHANNEL_COUNT = 1'b1;

    localparam logic [CHAN_CNT_W-1:0] CHANNEL_COUNT_RESET = CHAN_CNT_W'(1);

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_TICK = 1'b1
    } cmd_t;

    typedef enum logic {
        BK_IDLE,
        BK_READ
    } back_state_t;

    // Classified request handed from the front end to the back end
    typedef struct packed {
        cmd_t cmd;
        logic enable;
        logic push_ok;
        logic level;
    } item_t;

    typedef struct packed {
        logic                    push_accepted;
        logic [1:0]              speaker_bits;
        logic                    underrun;
        logic [COUNT_W-1:0]      samples_played;
        logic [COUNT_W-1:0]      underrun_total;
        logic [FILL_LEVEL_W-1:0] fill_level;
    } result_t;

    function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] s);
        logic [PTR_W-1:0] r;
        r = (s == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : s + PTR_W'(1);
        return r;
    endfunction

endpackage

// File: sv/osf_front.sv
// Front end: classifies incoming requests and queues them for the back end.
module osf_front (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    output logic                             full,
    input  logic                             cmd,
    input  logic signed [osf_pkg::SAMPLE_W-1:0] chan0_sample,
    input  logic signed [osf_pkg::SAMPLE_W-1:0] chan1_sample,
    input  logic signed [osf_pkg::SAMPLE_W-1:0] chan2_sample,
    input  logic signed [osf_pkg::SAMPLE_W-1:0] chan3_sample,
    input  logic                             enable,
    input  logic [osf_pkg::CHAN_CNT_W-1:0]   channel_count,
    output logic                             item_valid,
    output osf_pkg::item_t                   item,
    input  logic                             item_take
);
    import osf_pkg::*;

    logic signed [SAMPLE_W-1:0] chan [SAMPLE_FIELDS];
    logic [CHAN_CNT_W-1:0]      n_used;
    logic signed [SUM_W-1:0]    sum;
    item_t                      item_in;
    logic                       wr_en;

    item_t      entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign chan[0] = chan0_sample;
    assign chan[1] = chan1_sample;
    assign chan[2] = chan2_sample;
    assign chan[3] = chan3_sample;

    always_comb
    begin
        n_used = (channel_count > CHAN_CNT_W'(CHAN_LIMIT)) ? CHAN_CNT_W'(CHAN_LIMIT)
                                                          : channel_count;
        sum = '0;
        for (int c = 0; c < SAMPLE_FIELDS; c++)
        begin
            if (CHAN_CNT_W'(c) < n_used)
            begin
                sum = sum + SUM_W'(chan[c]);
            end
        end
        item_in.cmd     = cmd_t'(cmd);
        item_in.enable  = enable;
        item_in.push_ok = (n_used != '0);
        item_in.level   = !sum[SUM_W-1] && (sum != '0);
    end

    assign full       = (count_reg == 2'd2);
    assign wr_en      = push && !full;
    assign item_valid = (count_reg != 2'd0);
    assign item       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (item_take)
        begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({wr_en, item_take})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// File: sv/osf_back.sv
// Back end: level memory, ring pointers, counters and result assembly.
module osf_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    input  osf_pkg::item_t   item,
    output logic             item_take,
    input  logic             res_full,
    output logic             res_we,
    output osf_pkg::result_t res
);
    import osf_pkg::*;

    logic level_mem [QUEUE_DEPTH];
    logic rdata_reg;
    logic mem_we, mem_re;

    back_state_t        state_reg, state_next;
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [COUNT_W-1:0] read_count_reg, read_count_next;
    logic [COUNT_W-1:0] underrun_count_reg, underrun_count_next;
    logic               speaker_level_reg, speaker_level_next;
    logic               accepted, under;

    always_comb
    begin
        state_next          = state_reg;
        wr_ptr_next         = wr_ptr_reg;
        rd_ptr_next         = rd_ptr_reg;
        fill_next           = fill_reg;
        read_count_next     = read_count_reg;
        underrun_count_next = underrun_count_reg;
        speaker_level_next  = speaker_level_reg;
        mem_we              = 1'b0;
        mem_re              = 1'b0;
        res_we              = 1'b0;
        item_take           = 1'b0;
        accepted            = 1'b0;
        under               = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (item_valid && !res_full)
                begin
                    item_take = 1'b1;
                    if (!item.enable)
                    begin
                        res_we = 1'b1;
                    end
                    else if (item.cmd == CMD_PUSH)
                    begin
                        res_we = 1'b1;
                        if (item.push_ok && (fill_reg < FILL_W'(QUEUE_DEPTH)))
                        begin
                            mem_we      = 1'b1;
                            wr_ptr_next = next_slot(wr_ptr_reg);
                            fill_next   = fill_reg + FILL_W'(1);
                            accepted    = 1'b1;
                        end
                    end
                    else if (fill_reg != '0)
                    begin
                        // fetch the oldest level, finish next cycle
                        mem_re     = 1'b1;
                        state_next = BK_READ;
                    end
                    else
                    begin
                        speaker_level_next  = 1'b0;
                        underrun_count_next = underrun_count_reg + COUNT_W'(1);
                        under               = 1'b1;
                        res_we              = 1'b1;
                    end
                end
            end
            BK_READ:
            begin
                speaker_level_next = rdata_reg;
                rd_ptr_next        = next_slot(rd_ptr_reg);
                read_count_next    = read_count_reg + COUNT_W'(1);
                fill_next          = fill_reg - FILL_W'(1);
                res_we             = 1'b1;
                state_next         = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase

        res.push_accepted  = accepted;
        res.speaker_bits   = {speaker_level_next, 1'b0};
        res.underrun       = under;
        res.samples_played = read_count_next;
        res.underrun_total = underrun_count_next;
        res.fill_level     = FILL_LEVEL_W'(fill_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= BK_IDLE;
            wr_ptr_reg         <= '0;
            rd_ptr_reg         <= '0;
            fill_reg           <= '0;
            read_count_reg     <= '0;
            underrun_count_reg <= '0;
            speaker_level_reg  <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            wr_ptr_reg         <= wr_ptr_next;
            rd_ptr_reg         <= rd_ptr_next;
            fill_reg           <= fill_next;
            read_count_reg     <= read_count_next;
            underrun_count_reg <= underrun_count_next;
            speaker_level_reg  <= speaker_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            level_mem[wr_ptr_reg] <= item.level;
        end
        if (mem_re)
        begin
            rdata_reg <= level_mem[rd_ptr_reg];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_W'(QUEUE_DEPTH))
        else $error("fill level above queue depth");

    a_read_completes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |-> (res_we && !item_take))
        else $error("level read did not produce a result");

    a_read_start_room: assert property (@(posedge clk) disable iff (!rst_n)
        mem_re |-> (!res_full && fill_reg != '0))
        else $error("level read issued without room or data");

    a_pop_moves_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_READ) |=> (fill_reg == $past(fill_reg) - FILL_W'(1)
                                    && read_count_reg == $past(read_count_reg) + COUNT_W'(1)))
        else $error("pop did not move fill and read count together");

endmodule

// File: sv/osf_result_queue.sv
// Two-entry result queue between the back end and the result ports.
module osf_result_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             we,
    input  osf_pkg::result_t din,
    output logic             full,
    output logic             empty,
    input  logic             pop,
    output osf_pkg::result_t dout
);
    import osf_pkg::*;

    result_t    entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       rd_en;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign rd_en = pop && !empty;
    assign dout  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = we ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = rd_en ? !rd_ptr_reg : rd_ptr_reg;
        case ({we, rd_en})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// File: sv/one_bit_speaker_sample_fifo.sv
// Top level of the one-bit speaker sample FIFO: configuration registers and wiring.
//
// Each request is a push of one audio frame or an output tick, and each yields exactly
// one result. The back end finishes a push or an empty-queue tick straight from idle,
// while a tick that pops a queued level passes through a read state, because the
// 1024 x 1 level memory has a registered read port; no new request is taken until
// that read ends. Pushes flow at one request per cycle while the result queue has room.
// Two-entry queues sit before and after the back end, so push stays open while results
// wait to be popped, until the front queue fills. The level memory needs no clearing
// after reset; an entry is read only after it was written.
module one_bit_speaker_sample_fifo (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [osf_pkg::ADDR_W-1:0]           paddr,
    input  logic [osf_pkg::DATA_W-1:0]           pwdata,
    output logic [osf_pkg::DATA_W-1:0]           prdata,
    output logic                                 pready,
    input  logic                                 push,
    output logic                                 full,
    input  logic                                 cmd,
    input  logic signed [osf_pkg::SAMPLE_W-1:0]  chan0_sample,
    input  logic signed [osf_pkg::SAMPLE_W-1:0]  chan1_sample,
    input  logic signed [osf_pkg::SAMPLE_W-1:0]  chan2_sample,
    input  logic signed [osf_pkg::SAMPLE_W-1:0]  chan3_sample,
    output logic                                 empty,
    input  logic                                 pop,
    output logic                                 push_accepted,
    output logic [1:0]                           speaker_bits,
    output logic                                 underrun,
    output logic [osf_pkg::COUNT_W-1:0]          samples_played,
    output logic [osf_pkg::COUNT_W-1:0]          underrun_total,
    output logic [osf_pkg::FILL_LEVEL_W-1:0]     fill_level
);
    import osf_pkg::*;

    logic                  enable_reg;
    logic [CHAN_CNT_W-1:0] channel_count_reg;
    logic                  cfg_write;

    logic    item_valid, item_take;
    item_t   item;
    logic    res_we, res_full;
    result_t res_in, res_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            channel_count_reg <= CHANNEL_COUNT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_ENABLE:        enable_reg        <= pwdata[0];
                REG_CHANNEL_COUNT: channel_count_reg <= pwdata[CHAN_CNT_W-1:0];
                default:           enable_reg        <= enable_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_ENABLE:        prdata = DATA_W'(enable_reg);
            REG_CHANNEL_COUNT: prdata = DATA_W'(channel_count_reg);
            default:           prdata = '0;
        endcase
    end

    osf_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .cmd           (cmd),
        .chan0_sample  (chan0_sample),
        .chan1_sample  (chan1_sample),
        .chan2_sample  (chan2_sample),
        .chan3_sample  (chan3_sample),
        .enable        (enable_reg),
        .channel_count (channel_count_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_take     (item_take)
    );

    osf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .res_full   (res_full),
        .res_we     (res_we),
        .res        (res_in)
    );

    osf_result_queue u_result_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (res_we),
        .din   (res_in),
        .full  (res_full),
        .empty (empty),
        .pop   (pop),
        .dout  (res_out)
    );

    assign push_accepted  = res_out.push_accepted;
    assign speaker_bits   = res_out.speaker_bits;
    assign underrun       = res_out.underrun;
    assign samples_played = res_out.samples_played;
    assign underrun_total = res_out.underrun_total;
    assign fill_level     = res_out.fill_level;

endmodule
